// ===== src/mfde_pkg.sv =====
// shared types, constants and glyph table for the framebuffer draw engine
// no dependencies
`default_nettype none
package mfde_pkg;
  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;
  localparam int PageCount    = (ScreenHeight + 7) / 8;
  localparam int StoreBytes   = ScreenWidth * PageCount;
  localparam int AddrW        = $clog2(StoreBytes);

  localparam logic [2:0] ActClear = 3'd0;
  localparam logic [2:0] ActPixel = 3'd1;
  localparam logic [2:0] ActRect  = 3'd2;
  localparam logic [2:0] ActGlyph = 3'd3;
  localparam logic [2:0] ActRead  = 3'd4;

  // controller commands to the datapath
  typedef struct packed {
    logic load;      // capture request fields
    logic init_x;    // column counter back to start
    logic step_y;    // next row within column
    logic step_x;    // next column, row back to start
    logic clr_addr;  // clear sweep address to zero
    logic step_addr; // next sweep address
    logic rd_pix;    // read byte for current pixel
    logic wr_pix;    // write modified byte for current pixel
    logic wr_clr;    // write zero at sweep address
    logic rd_addr;   // read byte at request address
    logic cap_data;  // capture read data as result
    logic zero_data; // result is zero
  } ctrl_t;

  typedef struct packed {
    logic last_y;
    logic last_x;
    logic last_addr;
    logic empty;     // nothing to draw
    logic pix_ok;    // current pixel on screen
    logic addr_ok;   // request address in range
  } stat_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] c);
    logic [5:0] g;
    g = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) g = 6'(c - 8'h40);
    else if (c >= 8'h61 && c <= 8'h7A) g = 6'(c - 8'h60);
    else if (c >= 8'h30 && c <= 8'h39) g = 6'(c - 8'h30 + 8'd27);
    else if (c == 8'h3A) g = 6'd37;
    return g;
  endfunction

  function automatic logic [39:0] glyph_rom(input logic [5:0] g);
    logic [39:0] r;
    case (g)
      6'd1:  r = 40'h7C1211127C;  6'd2:  r = 40'h7F49494936;
      6'd3:  r = 40'h3E41414122;  6'd4:  r = 40'h7F4141221C;
      6'd5:  r = 40'h7F49494941;  6'd6:  r = 40'h7F09090901;
      6'd7:  r = 40'h3E4149497A;  6'd8:  r = 40'h7F0808087F;
      6'd9:  r = 40'h00417F4100;  6'd10: r = 40'h2040413F01;
      6'd11: r = 40'h7F08142241;  6'd12: r = 40'h7F40404040;
      6'd13: r = 40'h7F020C027F;  6'd14: r = 40'h7F0408107F;
      6'd15: r = 40'h3E4141413E;  6'd16: r = 40'h7F09090906;
      6'd17: r = 40'h3E4151215E;  6'd18: r = 40'h7F09192946;
      6'd19: r = 40'h4649494931;  6'd20: r = 40'h01017F0101;
      6'd21: r = 40'h3F4040403F;  6'd22: r = 40'h1F2040201F;
      6'd23: r = 40'h3F4038403F;  6'd24: r = 40'h6314081463;
      6'd25: r = 40'h0708700807;  6'd26: r = 40'h6151494543;
      6'd27: r = 40'h3E5149453E;  6'd28: r = 40'h00427F4000;
      6'd29: r = 40'h4261514946;  6'd30: r = 40'h2141454B31;
      6'd31: r = 40'h1814127F10;  6'd32: r = 40'h2745454539;
      6'd33: r = 40'h3C4A494930;  6'd34: r = 40'h0171090503;
      6'd35: r = 40'h3649494936;  6'd36: r = 40'h064949291E;
      6'd37: r = 40'h0036360000;
      default: r = 40'h0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/mono_framebuffer_draw_engine.sv =====
// 128x64 page-layout framebuffer draw engine, top level
// one request at a time; the next is taken the cycle after the result has been delivered
// reset starts a clearing sweep of all 1024 framebuffer bytes, no request taken meanwhile
// depends on mfde_pkg, mfde_ctrl, mfde_datapath, mfde_ram
`default_nettype none
module mono_framebuffer_draw_engine import mfde_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        action_i,
  input  wire logic signed [8:0] x_pos_i,
  input  wire logic signed [7:0] y_pos_i,
  input  wire logic [7:0]        rect_width_i,
  input  wire logic [6:0]        rect_height_i,
  input  wire logic              pen_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [9:0]        read_addr_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             read_data_o
);
  ctrl_t ctrl;
  stat_t stat;
  logic out_valid_raw, boot_q;

  // suppress the result of the reset sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) boot_q <= 1'b1;
    else if (ctrl.load) boot_q <= 1'b0;
  end

  mfde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .out_valid_o(out_valid_raw), .out_ready_i(out_ready_i || boot_q),
    .stat_i(stat), .ctrl_o(ctrl)
  );
  assign out_valid_o = out_valid_raw && !boot_q;

  mfde_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .action_i, .x_pos_i, .y_pos_i,
    .rect_width_i, .rect_height_i, .pen_i, .char_code_i, .read_addr_i,
    .stat_o(stat), .read_data_o
  );
endmodule
`default_nettype wire

// ===== src/mfde_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module mfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== src/mfde_datapath.sv =====
// coordinate counters, clipping, glyph lookup and framebuffer memory
// depends on mfde_pkg and mfde_ram
`default_nettype none
module mfde_datapath import mfde_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [8:0]  x_pos_i,
  input  wire logic signed [7:0]  y_pos_i,
  input  wire logic [7:0]         rect_width_i,
  input  wire logic [6:0]         rect_height_i,
  input  wire logic               pen_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [9:0]         read_addr_i,
  output stat_t                   stat_o,
  output logic [7:0]              read_data_o
);
  logic [2:0] act_q;
  logic signed [9:0] x0_q, y0_q, xc_q, yc_q;
  logic [7:0] w_q, dx_q;
  logic [6:0] h_q, dy_q;
  logic pen_q;
  logic [39:0] glyph_q;
  logic [9:0] raddr_q;
  logic [AddrW-1:0] sweep_q;
  logic [7:0] data_q;
  logic [7:0] ram_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= '0;
      act_q   <= ActClear;
      sweep_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        act_q   <= action_i;
        x0_q    <= 10'(x_pos_i);
        y0_q    <= 10'(y_pos_i);
        pen_q   <= pen_i;
        raddr_q <= read_addr_i;
        glyph_q <= glyph_rom(glyph_index(char_code_i));
        if (action_i == ActRect) begin
          w_q <= rect_width_i; h_q <= rect_height_i;
        end else if (action_i == ActGlyph) begin
          w_q <= 8'd5; h_q <= 7'd7;
        end else begin
          w_q <= 8'd1; h_q <= 7'd1;
        end
      end
      if (ctrl_i.init_x) begin
        xc_q <= x0_q; yc_q <= y0_q; dx_q <= '0; dy_q <= '0;
      end else if (ctrl_i.step_x) begin
        xc_q <= xc_q + 10'sd1; yc_q <= y0_q; dx_q <= dx_q + 8'd1; dy_q <= '0;
      end else if (ctrl_i.step_y) begin
        yc_q <= yc_q + 10'sd1; dy_q <= dy_q + 7'd1;
      end
      if (ctrl_i.clr_addr) sweep_q <= '0;
      else if (ctrl_i.step_addr) sweep_q <= sweep_q + 1'b1;
      if (ctrl_i.zero_data) data_q <= '0;
      else if (ctrl_i.cap_data) data_q <= ram_rd;
    end
  end

  logic pix_ok;
  logic [AddrW-1:0] pix_addr;
  logic [7:0] bitmask;
  logic pix_val;
  logic [2:0] gcol;
  logic [7:0] gbyte;
  assign pix_ok = (xc_q >= 0) && (xc_q < ScreenWidth) && (yc_q >= 0) && (yc_q < ScreenHeight);
  // page-layout byte index; width is a power of two here so this is a shift
  assign pix_addr = AddrW'(32'(xc_q) + 32'(yc_q >>> 3) * ScreenWidth);
  assign bitmask  = 8'b1 << yc_q[2:0];
  assign gcol     = dx_q[2:0];
  assign gbyte    = glyph_q[8*(4-gcol) +: 8];
  assign pix_val  = (act_q == ActGlyph) ? gbyte[dy_q[2:0]] : pen_q;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0] ram_wd;
  always_comb begin
    ram_we = 1'b0; ram_wd = '0; ram_addr = '0;
    if (ctrl_i.wr_clr) begin
      ram_we = 1'b1; ram_addr = sweep_q;
    end else if (ctrl_i.rd_addr) begin
      ram_addr = raddr_q[AddrW-1:0];
    end else if (ctrl_i.rd_pix) begin
      ram_addr = pix_addr;
    end else if (ctrl_i.wr_pix) begin
      ram_we = 1'b1; ram_addr = pix_addr;
      ram_wd = pix_val ? (ram_rd | bitmask) : (ram_rd & ~bitmask);
    end
  end

  mfde_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wd),
    .rdata_o (ram_rd)
  );

  assign stat_o.last_y    = (dy_q == h_q - 7'd1);
  assign stat_o.last_x    = (dx_q == w_q - 8'd1);
  assign stat_o.last_addr = (sweep_q == AddrW'(StoreBytes - 1));
  assign stat_o.empty     = (w_q == '0) || (h_q == '0);
  assign stat_o.pix_ok    = pix_ok;
  assign stat_o.addr_ok   = (32'(raddr_q) < StoreBytes);
  assign read_data_o      = data_q;
endmodule
`default_nettype wire

// ===== src/mfde_ctrl.sv =====
// command sequencer for the draw engine
// depends on mfde_pkg
`default_nettype none
module mfde_ctrl import mfde_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] action_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire stat_t      stat_i,
  output ctrl_t           ctrl_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SClear = 8'b00000010,
    SStart = 8'b00000100,
    SRead  = 8'b00001000,
    SWrite = 8'b00010000,
    SRdA   = 8'b00100000,
    SRdB   = 8'b01000000,
    SDone  = 8'b10000000
  } state_e;
  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == SIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q; ctrl_o = '0; out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        ctrl_o.load = 1'b1; ctrl_o.clr_addr = 1'b1; ctrl_o.zero_data = 1'b1;
        case (action_i)
          ActClear: state_d = SClear;
          ActPixel, ActRect, ActGlyph: state_d = SStart;
          ActRead: state_d = SRdA;
          default: state_d = SDone;
        endcase
      end
      SClear: begin
        ctrl_o.wr_clr = 1'b1; ctrl_o.step_addr = 1'b1;
        if (stat_i.last_addr) state_d = SDone;
      end
      SStart: begin
        ctrl_o.init_x = 1'b1;
        state_d = stat_i.empty ? SDone : SRead;
      end
      SRead: begin
        ctrl_o.rd_pix = 1'b1;
        state_d = SWrite;
      end
      SWrite: begin
        ctrl_o.wr_pix = stat_i.pix_ok;
        state_d = SRead;
        if (stat_i.last_y) begin
          if (stat_i.last_x) state_d = SDone;
          else ctrl_o.step_x = 1'b1;
        end else ctrl_o.step_y = 1'b1;
      end
      SRdA: begin
        ctrl_o.rd_addr = 1'b1;
        state_d = SRdB;
      end
      SRdB: begin
        if (stat_i.addr_ok) ctrl_o.cap_data = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

// ===== tb/mono_framebuffer_draw_engine_test.sv =====
// self-checking testbench for the framebuffer draw engine: directed table, then random requests
// depends on mfde_pkg and the mono_framebuffer_draw_engine top level
module mono_framebuffer_draw_engine_test import mfde_pkg::*; ();

  localparam int unsigned StallLimit = 300000;
  localparam int          RandCount  = 1620;
  // action codes with no command behind them
  localparam logic [2:0]  ActSpare5  = 3'd5;
  localparam logic [2:0]  ActSpare6  = 3'd6;
  localparam logic [2:0]  ActSpare7  = 3'd7;

  typedef struct {
    logic [2:0]        action;
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic [7:0]        w;
    logic [6:0]        h;
    logic              pen;
    logic [7:0]        code;
    logic [9:0]        addr;
    bit                typed;
    logic [7:0]        want;
  } req_t;

  // 5x7 font, first column in the top byte, bit 0 is the top row
  localparam logic [39:0] Font [38] = '{
    40'h0000000000, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
    40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946,
    40'h2141454B31, 40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        action_i = ActClear;
  logic signed [8:0] x_pos_i = '0;
  logic signed [7:0] y_pos_i = '0;
  logic [7:0]        rect_width_i = '0;
  logic [6:0]        rect_height_i = '0;
  logic              pen_i = 1'b0;
  logic [7:0]        char_code_i = '0;
  logic [9:0]        read_addr_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        read_data_o;

  logic [7:0] fb_model [StoreBytes];
  logic [7:0] expected_bytes [$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned per_action [8];
  int unsigned stall_cycles = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 72;
  bit hold_req = 0;
  int hold_left = 0;

  mono_framebuffer_draw_engine uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int font_slot(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 1 + int'(c - "A");
    if (c >= "a" && c <= "z") return 1 + int'(c - "a");
    if (c >= "0" && c <= "9") return 27 + int'(c - "0");
    if (c == ":") return 37;
    return 0;
  endfunction

  function automatic void plot(input int px, input int py, input logic on);
    int idx;
    if (px < 0 || px >= ScreenWidth || py < 0 || py >= ScreenHeight) return;
    idx = px + (py / 8) * ScreenWidth;
    fb_model[idx][py % 8] = on;
  endfunction

  // updates the frame model and returns the byte the block should deliver
  function automatic logic [7:0] apply_request(input req_t r);
    int x0, y0, g;
    logic [39:0] bits;
    x0 = int'(r.x);
    y0 = int'(r.y);
    case (r.action)
      ActClear: foreach (fb_model[k]) fb_model[k] = 8'h00;
      ActPixel: plot(x0, y0, r.pen);
      ActRect:
        for (int i = x0; i < x0 + int'(r.w); i++)
          for (int j = y0; j < y0 + int'(r.h); j++) plot(i, j, r.pen);
      ActGlyph: begin
        g = font_slot(r.code);
        bits = Font[g];
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 7; j++) plot(x0 + i, y0 + j, bits[39 - 8 * i - 7 + j]);
      end
      ActRead: if (int'(r.addr) < StoreBytes) return fb_model[r.addr];
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic req_t mk(input logic [2:0] a, input int x, input int y, input int w,
                              input int h, input logic pen, input logic [7:0] code,
                              input int addr, input bit typed = 0, input logic [7:0] want = 0);
    req_t r;
    r.action = a; r.x = 9'(x); r.y = 8'(y); r.w = 8'(w); r.h = 7'(h);
    r.pen = pen; r.code = code; r.addr = 10'(addr); r.typed = typed; r.want = want;
    return r;
  endfunction

  task automatic issue(input req_t r);
    in_valid_i    <= 1'b1;
    action_i      <= r.action;
    x_pos_i       <= r.x;
    y_pos_i       <= r.y;
    rect_width_i  <= r.w;
    rect_height_i <= r.h;
    pen_i         <= r.pen;
    char_code_i   <= r.code;
    read_addr_i   <= r.addr;
    do @(posedge clk_i); while (!in_ready_o);
    begin
      logic [7:0] p;
      p = apply_request(r);
      expected_bytes.push_back(r.typed ? r.want : p);
    end
    per_action[r.action]++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result read_data=%02h", read_data_o);
      end else begin
        logic [7:0] e;
        e = expected_bytes.pop_front();
        checked++;
        if (read_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: read_data expected %02h got %02h",
                     checked, e, read_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a handshake", stall_cycles);
      $display("mono_framebuffer_draw_engine regression: fail");
      $finish;
    end
  end

  initial begin
    req_t dir [$];
    req_t r;
    int cur_x, cur_y, last_x, last_y, sel;

    // the block comes out of reset with a cleared framebuffer
    foreach (fb_model[k]) fb_model[k] = 8'h00;

    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));
    dir.push_back(mk(ActPixel, 0, 0, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
    dir.push_back(mk(ActPixel, 127, 63, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h80));
    // off-screen pixels and coordinate extremes
    dir.push_back(mk(ActPixel, -1, 0, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActPixel, 128, 0, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActPixel, 0, 64, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActPixel, -256, -128, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActPixel, 255, 127, 0, 0, 1, 0, 0));
    dir.push_back(mk(ActPixel, 127, 63, 0, 0, 0, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));
    // empty rectangles, then a clipped one and the largest one
    dir.push_back(mk(ActRect, 10, 10, 0, 5, 1, 0, 0));
    dir.push_back(mk(ActRect, 10, 10, 5, 0, 1, 0, 0));
    dir.push_back(mk(ActRect, -3, -3, 10, 10, 1, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 2));
    dir.push_back(mk(ActRect, 0, 0, 255, 127, 1, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 517, 1, 8'hFF));
    dir.push_back(mk(ActClear, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 517, 1, 8'h00));
    // glyphs: folded case, blank for unknown codes, clipped cells
    dir.push_back(mk(ActGlyph, 0, 0, 0, 0, 0, "A", 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 0, 1, 8'h7C));
    dir.push_back(mk(ActGlyph, 6, 0, 0, 0, 1, "a", 0));
    dir.push_back(mk(ActGlyph, 0, 0, 0, 0, 1, "~", 0));
    dir.push_back(mk(ActRead, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
    dir.push_back(mk(ActGlyph, 125, 60, 0, 0, 0, ":", 0));
    dir.push_back(mk(ActGlyph, -3, -3, 0, 0, 0, "9", 0));
    dir.push_back(mk(ActSpare5, 1, 1, 1, 1, 1, "Z", 6, 1, 8'h00));
    dir.push_back(mk(ActSpare7, -1, -1, 255, 127, 1, 8'hFF, 1023, 1, 8'h00));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir[k]) issue(dir[k]);

    cur_x = 0; cur_y = 0; last_x = 0; last_y = 0;
    for (int n = 0; n < RandCount; n++) begin
      if (n == RandCount / 3) begin
        send_idle_pct = 72; recv_idle_pct = 21;
      end else if (n == 2 * RandCount / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (n == RandCount / 2) hold_req = 1;

      r.action = 3'($urandom); r.x = 9'($urandom); r.y = 8'($urandom);
      r.w = 8'($urandom); r.h = 7'($urandom); r.pen = 1'($urandom);
      r.code = 8'($urandom); r.addr = 10'($urandom); r.typed = 0; r.want = 0;
      if ($urandom_range(0, 9) == 0) begin
        r.x = 9'($urandom_range(0, 143) - 8); r.y = 8'($urandom_range(0, 79) - 8);
      end else begin
        r.x = 9'($urandom_range(0, 131) - 4); r.y = 8'($urandom_range(0, 67) - 4);
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) r.action = ActClear;
      else if (sel < 25) r.action = ActPixel;
      else if (sel < 42) begin
        r.action = ActRect;
        case ($urandom_range(0, 9))
          0: begin r.w = 8'($urandom_range(0, 255)); r.h = 7'($urandom_range(0, 2)); end
          1: begin r.w = 8'($urandom_range(0, 2)); r.h = 7'($urandom_range(0, 127)); end
          default: begin r.w = 8'($urandom_range(0, 16)); r.h = 7'($urandom_range(0, 12)); end
        endcase
      end else if (sel < 72) begin
        r.action = ActGlyph;
        // mostly text runs: printable characters with the cursor stepping by six
        if ($urandom_range(0, 4) != 0) begin
          if (cur_x > 124) begin
            cur_x = $urandom_range(0, 8) - 4; cur_y = $urandom_range(0, 63) - 3;
          end
          r.x = 9'(cur_x); r.y = 8'(cur_y);
          r.code = 8'($urandom_range(32, 122));
          cur_x += 6;
        end
      end else if (sel < 96) begin
        r.action = ActRead;
        if ($urandom_range(0, 1) == 0 && last_x >= 0 && last_x < ScreenWidth &&
            last_y >= 0 && last_y < ScreenHeight)
          r.addr = 10'(last_x + $urandom_range(0, 4) + (last_y / 8) * ScreenWidth);
      end
      if (r.action inside {ActPixel, ActRect, ActGlyph}) begin
        last_x = int'(r.x); last_y = int'(r.y);
      end
      issue(r);
    end
    in_valid_i <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d requests, %0d results checked: clear %0d, pixel %0d, rect %0d, glyph %0d,",
             dir.size() + RandCount, checked, per_action[ActClear], per_action[ActPixel],
             per_action[ActRect], per_action[ActGlyph]);
    $display("read %0d, unused codes %0d, %0d mismatches", per_action[ActRead],
             per_action[ActSpare5] + per_action[ActSpare6] + per_action[ActSpare7],
             mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("mono_framebuffer_draw_engine regression: pass");
    else
      $display("mono_framebuffer_draw_engine regression: fail");
    $finish;
  end
endmodule
